// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is low.
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication checked in the cycle after the condition, under the same clocking.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- design/deq_pkg.sv -----
`default_nettype none

package deq_pkg;

  // Number of slots in the ring store.
  localparam int unsigned CAPACITY = 1024;

  // Derived widths of the ring positions and of the fill count.
  localparam int unsigned ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned TOTAL_W = 11;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [TOTAL_W-1:0] total_t;

  // Operation codes carried by an input beat.
  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_POP_BACK   = 2'd1,
    OP_PUSH_FRONT = 2'd2,
    OP_POP_FRONT  = 2'd3
  } op_e;

  // Next ring position, wrapping at the last slot.
  function automatic addr_t ring_next(addr_t i);
    addr_t r;
    if (i == addr_t'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = addr_t'(i + addr_t'(1));
    end
    return r;
  endfunction

  // Previous ring position, wrapping at slot zero.
  function automatic addr_t ring_prev(addr_t i);
    addr_t r;
    if (i == '0) begin
      r = addr_t'(CAPACITY - 1);
    end else begin
      r = addr_t'(i - addr_t'(1));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/double_ended_queue_core.sv -----
// Double-ended queue of signed 32-bit values held in a ring RAM.
// Input channel: in_valid_i / in_stall_o carry one operation per beat
// (opcode_i: push back, pop back, push front, pop front; value_i for pushes).
// Output channel: out_valid_o / out_stall_i carry one result beat per
// operation: the front value (0 when empty), the count, an empty flag and a
// rejected flag (pop on empty or push on full, state left unchanged).
// The result is registered and appears in the cycle after the input beat is
// taken. A pop from the front that leaves values behind reads the new front
// from the RAM, whose read data is registered, and then loads the output.
// One operation per cycle is taken while the output is not stalled; after a
// front pop that leaves values behind, none is taken until its result loads.
// The front value of every other operation comes from a held register.
// Reset empties the queue at once; the RAM contents are not cleared, as
// only slots that were written are ever read.
// While the output beat is stalled the result is held, and a new input beat
// is taken only in a cycle in which the output register can be reloaded.
`default_nettype none

module double_ended_queue_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [1:0]                       opcode_i,
  input  wire logic signed [31:0]               value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic signed [31:0]                    front_value_o,
  output logic [deq_pkg::TOTAL_W-1:0]           entry_total_o,
  output logic                                  is_empty_o,
  output logic                                  rejected_o
);

  deq_pkg::addr_t head_q, head_d;
  deq_pkg::addr_t tail_q, tail_d;
  deq_pkg::cnt_t  count_q, count_d;
  logic signed [31:0] front_q, front_d;
  logic rd_q, rd_d;
  logic pend_q, pend_d;

  logic out_valid_q, out_valid_d;
  logic signed [31:0] out_front_q, out_front_d;
  deq_pkg::total_t out_total_q, out_total_d;
  logic out_empty_q, out_empty_d;
  logic out_rej_q, out_rej_d;

  logic out_free;
  logic accept;
  logic q_empty;
  logic q_full;
  logic rej;
  logic load_out;
  deq_pkg::op_e op;

  logic we;
  deq_pkg::addr_t waddr;
  logic re;
  deq_pkg::addr_t raddr;
  logic [31:0] rdata;

  // Handshake: take a beat only when no RAM read is outstanding, no fetched front
  // waits, and the output register is free or being emptied this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = rd_q || pend_q || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign op         = deq_pkg::op_e'(opcode_i);
  assign q_empty    = (count_q == '0);
  assign q_full     = (count_q == deq_pkg::cnt_t'(deq_pkg::CAPACITY));

  // Pointer update, RAM access and result selection.
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    front_d     = front_q;
    rd_d        = 1'b0;
    pend_d      = pend_q;
    rej         = 1'b0;
    we          = 1'b0;
    waddr       = tail_q;
    re          = 1'b0;
    raddr       = head_q;
    load_out    = 1'b0;
    out_front_d = out_front_q;
    out_total_d = out_total_q;
    out_empty_d = out_empty_q;
    out_rej_d   = out_rej_q;

    if (accept) begin
      unique case (op)
        deq_pkg::OP_PUSH_BACK: begin
          if (q_full) begin
            rej = 1'b1;
          end else begin
            we      = 1'b1;
            waddr   = tail_q;
            tail_d  = deq_pkg::ring_next(tail_q);
            count_d = deq_pkg::cnt_t'(count_q + deq_pkg::cnt_t'(1));
            if (q_empty) begin
              front_d = value_i;
            end
          end
        end
        deq_pkg::OP_PUSH_FRONT: begin
          if (q_full) begin
            rej = 1'b1;
          end else begin
            head_d  = deq_pkg::ring_prev(head_q);
            we      = 1'b1;
            waddr   = head_d;
            count_d = deq_pkg::cnt_t'(count_q + deq_pkg::cnt_t'(1));
            front_d = value_i;
          end
        end
        deq_pkg::OP_POP_BACK: begin
          if (q_empty) begin
            rej = 1'b1;
          end else begin
            tail_d  = deq_pkg::ring_prev(tail_q);
            count_d = deq_pkg::cnt_t'(count_q - deq_pkg::cnt_t'(1));
            if (count_d == '0) begin
              front_d = '0;
            end
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (q_empty) begin
            rej = 1'b1;
          end else begin
            head_d  = deq_pkg::ring_next(head_q);
            count_d = deq_pkg::cnt_t'(count_q - deq_pkg::cnt_t'(1));
            if (count_d == '0) begin
              front_d = '0;
            end else begin
              // The new front lives in the RAM: fetch it.
              re    = 1'b1;
              raddr = head_d;
              rd_d  = 1'b1;
            end
          end
        end
        default: begin
          rej = 1'b0;
        end
      endcase

      if (!rd_d) begin
        load_out    = 1'b1;
        out_front_d = front_d;
        out_total_d = deq_pkg::total_t'(count_d);
        out_empty_d = (count_d == '0);
        out_rej_d   = rej;
      end
    end

    // Read data returns: it becomes the held front value.
    if (rd_q) begin
      front_d = signed'(rdata);
      if (out_free) begin
        load_out    = 1'b1;
        out_front_d = signed'(rdata);
        out_total_d = deq_pkg::total_t'(count_q);
        out_empty_d = 1'b0;
        out_rej_d   = 1'b0;
      end else begin
        pend_d = 1'b1;
      end
    end

    // A fetched front waited for the output register.
    if (pend_q && out_free) begin
      load_out    = 1'b1;
      pend_d      = 1'b0;
      out_front_d = front_q;
      out_total_d = deq_pkg::total_t'(count_q);
      out_empty_d = 1'b0;
      out_rej_d   = 1'b0;
    end

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      front_q     <= '0;
      rd_q        <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      front_q     <= front_d;
      rd_q        <= rd_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    out_front_q <= out_front_d;
    out_total_q <= out_total_d;
    out_empty_q <= out_empty_d;
    out_rej_q   <= out_rej_d;
  end

  // Ring store.
  deq_ram #(
    .DEPTH (deq_pkg::CAPACITY),
    .WIDTH (deq_pkg::DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign front_value_o = out_front_q;
  assign entry_total_o = out_total_q;
  assign is_empty_o    = out_empty_q;
  assign rejected_o    = out_rej_q;

endmodule

`default_nettype wire

// ----- design/deq_ram.sv -----
`default_nettype none

// Simple dual-port RAM: one write port and one read port, registered read data.
module deq_ram #(
  parameter  int unsigned DEPTH = 1024,
  parameter  int unsigned WIDTH = 32,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/deq_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

// Port-level checks of the double-ended queue.
module deq_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic signed [31:0]          front_value_o,
  input wire logic [deq_pkg::TOTAL_W-1:0] entry_total_o,
  input wire logic                        is_empty_o,
  input wire logic                        rejected_o
);

  logic empty_ok;
  logic total_ok;
  logic reject_ok;

  // The empty flag agrees with the count, and the count stays within capacity.
  assign empty_ok  = (is_empty_o == (entry_total_o == '0));
  assign total_ok  = (entry_total_o <= deq_pkg::total_t'(deq_pkg::CAPACITY));
  assign reject_ok = (rejected_o == 1'b0) || (rejected_o == 1'b1);

  // A stalled result beat stays offered.
  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result beat dropped")

  // A stalled result beat holds the input channel off.
  `ASSERT_CLKD(a_stall_in, !(out_valid_o && out_stall_i) || in_stall_o, "input open on stall")

  // The empty flag agrees with the count.
  `ASSERT_CLKD(a_empty_cnt, !out_valid_o || empty_ok, "empty flag mismatch")

  // An empty queue shows a zero front value.
  `ASSERT_CLKD(a_empty_front, !out_valid_o || !is_empty_o || (front_value_o == '0), "front not zero")

  // The count never exceeds the capacity, and the rejected flag is a clean bit.
  `ASSERT_CLKD(a_cnt_range, !out_valid_o || (total_ok && reject_ok), "count beyond capacity")

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (.*);

`default_nettype wire

// ----- tb/double_ended_queue_core_tb.sv -----
`timescale 1ns / 1ps

module double_ended_queue_core_tb;

  // Give up long after the slowest correct run would have finished.
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [31:0]      front;
    deq_pkg::total_t  total;
    logic             empty;
    logic             rej;
  } deq_result_t;

  // Keeps its own copy of the deque and the results still owed by the block.
  class deque_scoreboard;
    logic [31:0]  slot_copy [deq_pkg::CAPACITY];
    int unsigned  head_pos;
    int unsigned  tail_pos;
    int unsigned  fill;
    deq_result_t  owed_results [$];
    int unsigned  fail_count;

    function new();
      head_pos   = 0;
      tail_pos   = 0;
      fill       = 0;
      fail_count = 0;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    function int unsigned occupancy();
      return fill;
    endfunction

    // Apply one accepted operation to the copy and queue the result it owes.
    function void note_operation(deq_pkg::op_e op, logic [31:0] value);
      deq_result_t r;
      r.rej = 1'b0;
      case (op)
        deq_pkg::OP_PUSH_BACK: begin
          if (fill >= deq_pkg::CAPACITY) begin
            r.rej = 1'b1;
          end else begin
            slot_copy[tail_pos] = value;
            tail_pos = (tail_pos + 1) % deq_pkg::CAPACITY;
            fill++;
          end
        end
        deq_pkg::OP_PUSH_FRONT: begin
          if (fill >= deq_pkg::CAPACITY) begin
            r.rej = 1'b1;
          end else begin
            head_pos = (head_pos + deq_pkg::CAPACITY - 1) % deq_pkg::CAPACITY;
            slot_copy[head_pos] = value;
            fill++;
          end
        end
        deq_pkg::OP_POP_BACK: begin
          if (fill == 0) begin
            r.rej = 1'b1;
          end else begin
            tail_pos = (tail_pos + deq_pkg::CAPACITY - 1) % deq_pkg::CAPACITY;
            fill--;
          end
        end
        default: begin
          if (fill == 0) begin
            r.rej = 1'b1;
          end else begin
            head_pos = (head_pos + 1) % deq_pkg::CAPACITY;
            fill--;
          end
        end
      endcase
      r.front = (fill != 0) ? slot_copy[head_pos] : 32'd0;
      r.total = deq_pkg::total_t'(fill);
      r.empty = (fill == 0);
      owed_results = {owed_results, r};
    endfunction

    // Compare one result beat with the oldest result owed.
    function void check_result(logic [31:0] front, deq_pkg::total_t total, logic empty,
                               logic rej);
      deq_result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: result beat with none owed: front %0d total %0d empty %0b rejected %0b",
                 $time, $signed(front), total, empty, rej);
        fail_count++;
      end else begin
        want = owed_results[0];
        owed_results.delete(0);
        if (front !== want.front) begin
          $display("%0t: front value expected %0d, actual %0d",
                   $time, $signed(want.front), $signed(front));
          fail_count++;
        end
        if (total !== want.total) begin
          $display("%0t: entry total expected %0d, actual %0d", $time, want.total, total);
          fail_count++;
        end
        if (empty !== want.empty) begin
          $display("%0t: empty flag expected %0b, actual %0b", $time, want.empty, empty);
          fail_count++;
        end
        if (rej !== want.rej) begin
          $display("%0t: rejected flag expected %0b, actual %0b", $time, want.rej, rej);
          fail_count++;
        end
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         opcode_i;
  logic signed [31:0] value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] front_value_o;
  deq_pkg::total_t    entry_total_o;
  logic               is_empty_o;
  logic               rejected_o;

  deque_scoreboard deque_sb;
  int unsigned     beats_sent = 0;
  int unsigned     idle_mode  = 0;
  int unsigned     cycle_count = 0;

  double_ended_queue_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .front_value_o (front_value_o),
    .entry_total_o (entry_total_o),
    .is_empty_o    (is_empty_o),
    .rejected_o    (rejected_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idling modes: none, sender idle, receiver stalling, both at a lower rate.
  function automatic int unsigned sender_idle_pct();
    case (idle_mode)
      1:       return 63;
      3:       return 21;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct();
    case (idle_mode)
      2:       return 63;
      3:       return 21;
      default: return 0;
    endcase
  endfunction

  // The receiver stalls at random according to the current mode.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct());
  end

  // Every result beat taken is checked against the oldest owed result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      deque_sb.check_result(front_value_o, entry_total_o, is_empty_o, rejected_o);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("double_ended_queue_core_tb NOT OK");
      $finish;
    end
  end

  // Drive one operation beat and hold it until the block takes it.
  task automatic send_op(deq_pkg::op_e op, logic [31:0] value);
    idle_mode = (beats_sent / 100) % 4;
    while ($urandom_range(99) < sender_idle_pct()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    value_i    <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    deque_sb.note_operation(op, value);
    beats_sent++;
  endtask

  // Stop sending until every owed result has come back.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (deque_sb.pending() != 0) @(posedge clk_i);
  endtask

  // Mostly uniform values, with the extremes mixed in.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic deq_pkg::op_e pick_op(int unsigned push_pct);
    if ($urandom_range(99) < push_pct) begin
      return $urandom_range(1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
    end
    return $urandom_range(1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
  endfunction

  task automatic run_random(int unsigned count, int unsigned push_pct);
    repeat (count) send_op(pick_op(push_pct), pick_value());
  endtask

  initial begin
    deque_sb    = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    opcode_i    = deq_pkg::OP_PUSH_BACK;
    value_i     = '0;
    out_stall_i = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed: pops on empty, extreme values at both ends, back-to-back
    // front pops and pointer wrap at slot zero in both directions.
    send_op(deq_pkg::OP_POP_BACK,   32'd0);
    send_op(deq_pkg::OP_POP_FRONT,  32'd0);
    send_op(deq_pkg::OP_PUSH_BACK,  32'h7fff_ffff);
    send_op(deq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
    send_op(deq_pkg::OP_PUSH_BACK,  32'h0000_0000);
    send_op(deq_pkg::OP_PUSH_FRONT, 32'hffff_ffff);
    send_op(deq_pkg::OP_POP_FRONT,  32'hffff_ffff);
    send_op(deq_pkg::OP_POP_BACK,   32'h1234_5678);
    send_op(deq_pkg::OP_PUSH_BACK,  32'h5555_5555);
    send_op(deq_pkg::OP_PUSH_FRONT, 32'haaaa_aaaa);
    send_op(deq_pkg::OP_POP_FRONT,  32'd0);
    send_op(deq_pkg::OP_POP_FRONT,  32'd0);
    send_op(deq_pkg::OP_POP_BACK,   32'd0);
    send_op(deq_pkg::OP_POP_BACK,   32'd0);
    send_op(deq_pkg::OP_POP_FRONT,  32'd0);
    send_op(deq_pkg::OP_PUSH_FRONT, 32'd1);
    send_op(deq_pkg::OP_POP_BACK,   32'd0);
    send_op(deq_pkg::OP_PUSH_BACK,  32'd2);
    send_op(deq_pkg::OP_POP_FRONT,  32'd0);
    send_op(deq_pkg::OP_POP_BACK,   32'd0);
    hold_until_drained();

    // A random walk near empty, so pops on empty keep turning up.
    run_random(350, 55);
    hold_until_drained();

    // Fill to capacity, then push on full and turn over at the full mark.
    while (deque_sb.occupancy() < deq_pkg::CAPACITY) begin
      send_op($urandom_range(1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
              pick_value());
    end
    repeat (3) send_op(deq_pkg::OP_PUSH_BACK, pick_value());
    repeat (3) send_op(deq_pkg::OP_PUSH_FRONT, pick_value());
    send_op(deq_pkg::OP_POP_FRONT,  32'd0);
    send_op(deq_pkg::OP_PUSH_BACK,  pick_value());
    send_op(deq_pkg::OP_POP_BACK,   32'd0);
    send_op(deq_pkg::OP_PUSH_FRONT, pick_value());
    send_op(deq_pkg::OP_PUSH_BACK,  pick_value());
    hold_until_drained();

    // Drain-heavy traffic from a full store.
    run_random(500, 10);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (deque_sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (deque_sb.fail_count == 0 && deque_sb.pending() == 0) begin
      $display("double_ended_queue_core_tb OK");
    end else begin
      $display("double_ended_queue_core_tb NOT OK");
    end
    $finish;
  end

endmodule
